// ===== rtl/core/dms_pkg.sv =====
// Shared types, codes and constants for the drive mode selector.
package dms_pkg;

    localparam int COUNT_BITS_DEF = 8;
    localparam int CFG_WIDTH      = 8;
    localparam int CFG_ADDR_WIDTH = 1;

    localparam logic [1:0] MODE_MANUAL = 2'd0;
    localparam logic [1:0] MODE_AUTO   = 2'd1;
    localparam logic [1:0] MODE_ESTOP  = 2'd2;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_HOST  = 2'd1;
    localparam logic [1:0] CMD_FORCE = 2'd2;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_LONG_PRESS = 1'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_DEBOUNCE   = 1'd1;

    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 8'd30;
    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 8'd5;

    typedef struct packed {
        logic [1:0] command;
        logic       mode_button;
        logic       start_button;
        logic       request_valid;
        logic [1:0] requested_mode;
    } in_t;

    typedef struct packed {
        logic       changed;
        logic [1:0] current_mode;
    } out_t;

endpackage

// ===== rtl/core/drive_mode_selector_with_estop_core.sv =====
// Top level of the drive mode selector with emergency stop.
//
//  channel | ports          | payload      | accepted when
//  --------+----------------+--------------+----------------------
//  input   | s_valid/s_ready| dms_pkg::in_t| s_valid && s_ready
//  result  | m_valid/m_ready| dms_pkg::out_t| m_valid && m_ready
//  config  | cfg_wr_en      | cfg_addr/data| cfg_wr_en high
//
// One item per cycle sustained while the result is taken; an accepted input item
// passes through the input register, then the result register.
// An input register feeds the step logic, which updates the mode state and
// loads the result register in the same cycle.
// Reset (synchronous, active low) empties both registers, selects estop and
// restores the register defaults.
// A stalled result holds the step stage; the input register takes at most one
// more item, then s_ready drops until the result is taken.
module drive_mode_selector_with_estop_core #(
    parameter int COUNT_BITS = dms_pkg::COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  dms_pkg::in_t                       s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output dms_pkg::out_t                      m_data,
    input  logic                               cfg_wr_en,
    input  logic [dms_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [dms_pkg::CFG_WIDTH-1:0]      cfg_wr_data
);

    logic [dms_pkg::CFG_WIDTH-1:0] long_press_reg;
    logic [dms_pkg::CFG_WIDTH-1:0] debounce_reg;

    logic                  in_valid_reg;
    dms_pkg::in_t          in_data_reg;
    logic                  out_valid_reg;
    dms_pkg::out_t         out_data_reg;

    logic [1:0]            mode_reg;
    logic [COUNT_BITS-1:0] hold_reg;
    logic [COUNT_BITS-1:0] quiet_reg;
    logic                  last_mb_reg;
    logic                  last_sb_reg;

    logic [1:0]            mode_next;
    logic [COUNT_BITS-1:0] hold_next;
    logic [COUNT_BITS-1:0] quiet_next;
    logic                  last_mb_next;
    logic                  last_sb_next;
    dms_pkg::out_t         result;

    logic                  advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    dms_step #(
        .COUNT_BITS(COUNT_BITS)
    ) u_step (
        .item                  (in_data_reg),
        .long_press_ticks      (long_press_reg),
        .debounce_ticks        (debounce_reg),
        .mode                  (mode_reg),
        .hold_count            (hold_reg),
        .quiet_count           (quiet_reg),
        .last_mode_button      (last_mb_reg),
        .last_start_button     (last_sb_reg),
        .mode_next             (mode_next),
        .hold_count_next       (hold_next),
        .quiet_count_next      (quiet_next),
        .last_mode_button_next (last_mb_next),
        .last_start_button_next(last_sb_next),
        .result                (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg <= dms_pkg::LONG_PRESS_RESET;
            debounce_reg   <= dms_pkg::DEBOUNCE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                dms_pkg::REG_LONG_PRESS: long_press_reg <= cfg_wr_data;
                dms_pkg::REG_DEBOUNCE:   debounce_reg   <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= dms_pkg::MODE_ESTOP;
            hold_reg      <= '0;
            quiet_reg     <= '0;
            last_mb_reg   <= 1'b0;
            last_sb_reg   <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                hold_reg      <= hold_next;
                quiet_reg     <= quiet_next;
                last_mb_reg   <= last_mb_next;
                last_sb_reg   <= last_sb_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule

// ===== rtl/core/dms_step.sv =====
// Next-state and result logic for one item of the drive mode selector.
module dms_step #(
    parameter int COUNT_BITS = dms_pkg::COUNT_BITS_DEF
) (
    input  dms_pkg::in_t                  item,
    input  logic [dms_pkg::CFG_WIDTH-1:0] long_press_ticks,
    input  logic [dms_pkg::CFG_WIDTH-1:0] debounce_ticks,
    input  logic [1:0]                    mode,
    input  logic [COUNT_BITS-1:0]         hold_count,
    input  logic [COUNT_BITS-1:0]         quiet_count,
    input  logic                          last_mode_button,
    input  logic                          last_start_button,
    output logic [1:0]                    mode_next,
    output logic [COUNT_BITS-1:0]         hold_count_next,
    output logic [COUNT_BITS-1:0]         quiet_count_next,
    output logic                          last_mode_button_next,
    output logic                          last_start_button_next,
    output dms_pkg::out_t                 result
);

    localparam int CW = (COUNT_BITS > dms_pkg::CFG_WIDTH) ? COUNT_BITS : dms_pkg::CFG_WIDTH;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] hold_inc;
    logic [COUNT_BITS-1:0] quiet_load;
    logic [CW-1:0]         deb_wide;
    logic                  long_hit;
    logic                  changed;
    logic                  mb;
    logic                  sb;

    assign mb       = item.mode_button;
    assign sb       = item.start_button;
    assign hold_inc = (hold_count < COUNT_MAX) ? hold_count + COUNT_BITS'(1) : hold_count;
    assign long_hit = CW'(hold_inc) >= CW'(long_press_ticks);
    assign deb_wide = CW'(debounce_ticks);
    assign quiet_load = (deb_wide > CW'(COUNT_MAX)) ? COUNT_MAX : deb_wide[COUNT_BITS-1:0];

    always_comb begin
        mode_next              = mode;
        hold_count_next        = hold_count;
        quiet_count_next       = quiet_count;
        last_mode_button_next  = last_mode_button;
        last_start_button_next = last_start_button;
        changed                = 1'b0;
        case (item.command)
            dms_pkg::CMD_TICK: begin
                if (mode == dms_pkg::MODE_ESTOP && mb && long_hit) begin
                    mode_next              = dms_pkg::MODE_MANUAL;
                    hold_count_next        = '0;
                    last_mode_button_next  = 1'b0;
                    last_start_button_next = sb;
                    quiet_count_next       = quiet_load;
                    changed                = 1'b1;
                end else begin
                    hold_count_next = (mode == dms_pkg::MODE_ESTOP && mb) ? hold_inc : '0;
                    if (quiet_count != '0) begin
                        quiet_count_next = quiet_count - COUNT_BITS'(1);
                    end else begin
                        last_mode_button_next  = mb;
                        last_start_button_next = sb;
                        if (last_start_button && !sb && mode == dms_pkg::MODE_ESTOP) begin
                            mode_next        = dms_pkg::MODE_MANUAL;
                            quiet_count_next = quiet_load;
                            changed          = 1'b1;
                        end else if (last_mode_button && !mb && mode != dms_pkg::MODE_ESTOP) begin
                            mode_next = (mode == dms_pkg::MODE_MANUAL) ? dms_pkg::MODE_AUTO
                                                                       : dms_pkg::MODE_MANUAL;
                            quiet_count_next = quiet_load;
                            changed          = 1'b1;
                        end
                    end
                end
            end
            dms_pkg::CMD_HOST: begin
                if (item.request_valid && mode != dms_pkg::MODE_ESTOP &&
                    (item.requested_mode == dms_pkg::MODE_MANUAL ||
                     item.requested_mode == dms_pkg::MODE_AUTO) &&
                    item.requested_mode != mode) begin
                    mode_next = item.requested_mode;
                    changed   = 1'b1;
                end
            end
            dms_pkg::CMD_FORCE: begin
                changed   = (mode != dms_pkg::MODE_ESTOP);
                mode_next = dms_pkg::MODE_ESTOP;
            end
            default: begin
            end
        endcase
        result.changed      = changed;
        result.current_mode = mode_next;
    end

endmodule

// ===== rtl/core/dms_checker.sv =====
// Port-level assertions for the drive mode selector, bound to the top level.
module dms_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input dms_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input dms_pkg::out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_mode_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.current_mode != 2'd3)
        else $error("unused mode code on result");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

endmodule

bind drive_mode_selector_with_estop_core dms_checker u_dms_checker (.*);

// ===== sim/dms_mode_checker.sv =====
// Checker for the drive mode selector: tracks mode state, predicts each item's result and compares.
module dms_mode_checker #(
    parameter int CNT_BITS = dms_pkg::COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  dms_pkg::in_t                       s_data,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  dms_pkg::out_t                      m_data,
    input  logic                               cfg_wr_en,
    input  logic [dms_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [dms_pkg::CFG_WIDTH-1:0]      cfg_wr_data,
    output int                                 mismatches,
    output int                                 reports_open
);
    import dms_pkg::*;

    localparam int CNT_MAX = (1 << CNT_BITS) - 1;

    logic [CFG_WIDTH-1:0] long_press;
    logic [CFG_WIDTH-1:0] debounce;
    logic [1:0]           mode;
    int unsigned          hold_cnt;
    int unsigned          quiet_cnt;
    logic                 last_mb;
    logic                 last_sb;
    out_t                 mode_reports[$];
    int                   errors;

    function automatic logic button_tick(logic mb, logic sb);
        int unsigned quiet_load;
        quiet_load = (debounce > CNT_MAX) ? CNT_MAX : debounce;
        if (mode == MODE_ESTOP && mb) begin
            if (hold_cnt < CNT_MAX)
                hold_cnt++;
            if (hold_cnt >= long_press) begin
                mode      = MODE_MANUAL;
                hold_cnt  = 0;
                last_mb   = 1'b0;
                last_sb   = sb;
                quiet_cnt = quiet_load;
                return 1'b1;
            end
        end else begin
            hold_cnt = 0;
        end
        if (quiet_cnt > 0) begin
            quiet_cnt--;
            return 1'b0;
        end
        if (last_sb && !sb && mode == MODE_ESTOP) begin
            mode      = MODE_MANUAL;
            last_mb   = mb;
            last_sb   = sb;
            quiet_cnt = quiet_load;
            return 1'b1;
        end
        if (last_mb && !mb && mode != MODE_ESTOP) begin
            mode      = (mode == MODE_MANUAL) ? MODE_AUTO : MODE_MANUAL;
            last_mb   = mb;
            last_sb   = sb;
            quiet_cnt = quiet_load;
            return 1'b1;
        end
        last_mb = mb;
        last_sb = sb;
        return 1'b0;
    endfunction

    function automatic out_t next_mode_report(in_t it);
        out_t r;
        logic hit;
        hit = 1'b0;
        case (it.command)
            CMD_TICK: begin
                hit = button_tick(it.mode_button, it.start_button);
            end
            CMD_HOST: begin
                if (it.request_valid && mode != MODE_ESTOP &&
                    (it.requested_mode == MODE_MANUAL || it.requested_mode == MODE_AUTO) &&
                    it.requested_mode != mode) begin
                    mode = it.requested_mode;
                    hit  = 1'b1;
                end
            end
            CMD_FORCE: begin
                hit  = (mode != MODE_ESTOP);
                mode = MODE_ESTOP;
            end
            default: begin
            end
        endcase
        r.changed      = hit;
        r.current_mode = mode;
        return r;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            long_press = LONG_PRESS_RESET;
            debounce   = DEBOUNCE_RESET;
            mode       = MODE_ESTOP;
            hold_cnt   = 0;
            quiet_cnt  = 0;
            last_mb    = 1'b0;
            last_sb    = 1'b0;
            errors     = 0;
            mode_reports.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_LONG_PRESS: long_press = cfg_wr_data;
                    REG_DEBOUNCE:   debounce   = cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (mode_reports.size() == 0) begin
                    $display("%0t: unexpected result changed=%0d mode=%0d", $time,
                             m_data.changed, m_data.current_mode);
                    errors++;
                end else begin
                    want = mode_reports.pop_front();
                    if (m_data.changed !== want.changed) begin
                        $display("%0t: changed expected %0d actual %0d", $time,
                                 want.changed, m_data.changed);
                        errors++;
                    end
                    if (m_data.current_mode !== want.current_mode) begin
                        $display("%0t: current_mode expected %0d actual %0d", $time,
                                 want.current_mode, m_data.current_mode);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                mode_reports.push_back(next_mode_report(s_data));
        end
        mismatches   <= errors;
        reports_open <= mode_reports.size();
    end
endmodule

// ===== sim/tb_drive_mode_selector_with_estop_core.sv =====
// Testbench top for the drive mode selector: reset, register setup, stimulus and verdict.
module tb_drive_mode_selector_with_estop_core;
    import dms_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    in_t                       s_data;
    logic                      m_valid;
    logic                      m_ready;
    out_t                      m_data;
    logic                      cfg_wr_en;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr;
    logic [CFG_WIDTH-1:0]      cfg_wr_data;
    int                        mismatches;
    int                        reports_open;
    int                        stall_cycles;
    bit                        idle_on;
    int                        lp_now;

    drive_mode_selector_with_estop_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    dms_mode_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data),
        .mismatches   (mismatches),
        .reports_open (reports_open)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(99) >= 16);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic in_t mk(logic [1:0] cmd, logic mb, logic sb, logic rv, logic [1:0] rq);
        in_t it;
        it.command        = cmd;
        it.mode_button    = mb;
        it.start_button   = sb;
        it.request_valid  = rv;
        it.requested_mode = rq;
        return it;
    endfunction

    function automatic in_t any_item();
        logic [31:0] raw;
        raw = $urandom;
        return in_t'(raw[$bits(in_t)-1:0]);
    endfunction

    // button tick with random content in the host fields
    function automatic in_t tick(logic mb, logic sb);
        in_t it;
        it              = any_item();
        it.command      = CMD_TICK;
        it.mode_button  = mb;
        it.start_button = sb;
        return it;
    endfunction

    task automatic send_item(input in_t item);
        if (idle_on && $urandom_range(99) < 16) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (reports_open != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_timing(input int lp, input int db);
        wait_drain();
        write_reg(REG_LONG_PRESS, CFG_WIDTH'(lp));
        write_reg(REG_DEBOUNCE, CFG_WIDTH'(db));
        lp_now = lp;
    endtask

    task automatic run_phase(input int budget);
        int sent;
        int kind;
        int n;
        in_t it;
        sent = 0;
        while (sent < budget) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                // long hold of mode, often from estop, then release
                if ($urandom_range(1) == 1) begin
                    send_item(mk(CMD_FORCE, 1'($urandom), 1'($urandom), 1'($urandom),
                                 2'($urandom)));
                    sent++;
                end
                n = (lp_now > 40 && $urandom_range(3) != 0) ? 40 : lp_now + 3;
                n = $urandom_range(1, n);
                repeat (n) send_item(tick(1'b1, $urandom_range(9) == 0));
                send_item(tick(1'b0, $urandom_range(9) == 0));
                sent += n + 1;
            end else if (kind < 55) begin
                n = $urandom_range(1, 3);
                repeat (n) send_item(tick(1'b0, 1'b1));
                send_item(tick(1'b0, 1'b0));
                sent += n + 1;
            end else if (kind < 70) begin
                n = $urandom_range(1, 3);
                repeat (n) send_item(tick(1'b1, 1'b0));
                send_item(tick(1'b0, 1'b0));
                sent += n + 1;
            end else if (kind < 78) begin
                n = $urandom_range(1, 8);
                repeat (n) send_item(tick(1'b0, 1'b0));
                sent += n;
            end else if (kind < 88) begin
                it                = any_item();
                it.command        = CMD_HOST;
                it.request_valid  = $urandom_range(5) != 0;
                if ($urandom_range(4) != 0)
                    it.requested_mode = $urandom_range(1) ? MODE_AUTO : MODE_MANUAL;
                send_item(it);
                sent++;
            end else if (kind < 92) begin
                it         = any_item();
                it.command = CMD_FORCE;
                send_item(it);
                sent++;
            end else begin
                send_item(any_item());
                sent++;
            end
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wr_data = '0;
        idle_on     = 1'b1;
        lp_now      = LONG_PRESS_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: start release, mode toggle, host requests, force, long press
        set_timing(3, 2);
        send_item(mk(2'd3, 1'b1, 1'b1, 1'b1, 2'd3));
        send_item(mk(CMD_TICK, 1'b0, 1'b0, 1'b0, MODE_MANUAL));
        send_item(mk(CMD_HOST, 1'b0, 1'b0, 1'b1, MODE_MANUAL));
        send_item(mk(CMD_TICK, 1'b0, 1'b1, 1'b0, MODE_MANUAL));
        send_item(mk(CMD_TICK, 1'b0, 1'b0, 1'b0, MODE_MANUAL));
        send_item(mk(CMD_TICK, 1'b1, 1'b0, 1'b0, MODE_MANUAL));
        send_item(mk(CMD_TICK, 1'b1, 1'b0, 1'b0, MODE_MANUAL));
        send_item(mk(CMD_TICK, 1'b1, 1'b0, 1'b0, MODE_MANUAL));
        send_item(mk(CMD_TICK, 1'b0, 1'b0, 1'b0, MODE_MANUAL));
        send_item(mk(CMD_HOST, 1'b0, 1'b0, 1'b1, MODE_AUTO));
        send_item(mk(CMD_HOST, 1'b1, 1'b1, 1'b1, MODE_MANUAL));
        send_item(mk(CMD_HOST, 1'b0, 1'b0, 1'b1, MODE_ESTOP));
        send_item(mk(CMD_HOST, 1'b0, 1'b0, 1'b1, 2'd3));
        send_item(mk(CMD_HOST, 1'b0, 1'b0, 1'b0, MODE_AUTO));
        send_item(mk(CMD_FORCE, 1'b0, 1'b0, 1'b0, MODE_MANUAL));
        send_item(mk(CMD_FORCE, 1'b1, 1'b1, 1'b1, 2'd3));
        repeat (3) send_item(mk(CMD_TICK, 1'b1, 1'b0, 1'b0, MODE_MANUAL));
        send_item(mk(CMD_FORCE, 1'b0, 1'b0, 1'b0, MODE_MANUAL));
        // mode release while in estop
        send_item(mk(CMD_TICK, 1'b1, 1'b0, 1'b0, MODE_MANUAL));
        send_item(mk(CMD_TICK, 1'b0, 1'b0, 1'b0, MODE_MANUAL));
        // zero long press count
        set_timing(0, 0);
        send_item(mk(CMD_TICK, 1'b1, 1'b0, 1'b0, MODE_MANUAL));
        // long press while ticks are being skipped
        set_timing(1, 5);
        send_item(mk(CMD_FORCE, 1'b0, 1'b0, 1'b0, MODE_MANUAL));
        send_item(mk(CMD_TICK, 1'b0, 1'b1, 1'b0, MODE_MANUAL));
        send_item(mk(CMD_TICK, 1'b0, 1'b0, 1'b0, MODE_MANUAL));
        send_item(mk(CMD_FORCE, 1'b0, 1'b0, 1'b0, MODE_MANUAL));
        send_item(mk(CMD_TICK, 1'b1, 1'b0, 1'b0, MODE_MANUAL));

        set_timing(1, 0);
        run_phase(150);
        set_timing(255, 255);
        run_phase(150);
        idle_on = 1'b0;
        set_timing(LONG_PRESS_RESET, DEBOUNCE_RESET);
        run_phase(150);
        idle_on = 1'b1;
        set_timing($urandom_range(1, 20), $urandom_range(0, 10));
        run_phase(150);
        set_timing(0, $urandom_range(0, 255));
        run_phase(150);
        set_timing($urandom_range(2, 12), 1);
        run_phase(150);

        wait_drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && reports_open == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
